// ----- sv/lobfm_pkg.sv -----
// shared types and constants for the limit order book matcher
`timescale 1ns / 1ps
package lobfm_pkg;

   localparam int WORD_BITS = 32;
   localparam int WORD_LG   = 5;
   localparam int TOTAL_W   = 36;
   localparam int REQ_W     = 144;
   localparam int RSP_W     = 200;

   typedef enum logic [1:0] {
      KIND_FILL  = 2'd0,
      KIND_ERROR = 2'd1,
      KIND_SUM   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2,
      ERR_LIMIT = 2'd3
   } err_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RED,
      ST_ORD,
      ST_FILL,
      ST_BMCLR,
      ST_SCAN,
      ST_SCANCHK,
      ST_NEW,
      ST_NEWLVL,
      ST_NBSET,
      ST_SUM
   } state_type;

endpackage

// ----- sv/lobfm_ram.sv -----
// single port pair synchronous ram with registered read data
`timescale 1ns / 1ps
module lobfm_ram #(
   parameter int AW    = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   localparam int DEPTH = 2 ** AW;

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

// ----- sv/lobfm_bitscan.sv -----
// find the highest or lowest set bit of one occupancy word
`timescale 1ns / 1ps
module lobfm_bitscan
   import lobfm_pkg::*;
(
   input  logic [WORD_BITS-1:0] word,
   input  logic                 lowest,
   output logic                 found,
   output logic [WORD_LG-1:0]   idx
);
   always_comb begin
      found = |word;
      idx   = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (!lowest && word[i]) begin
            idx = WORD_LG'(i);
         end
         if (lowest && word[WORD_BITS-1-i]) begin
            idx = WORD_LG'(WORD_BITS-1-i);
         end
      end
   end
endmodule

// ----- sv/limit_order_book_fifo_match.sv -----
// top level of the price-time priority limit order book matcher
`timescale 1ns / 1ps
// usage:
//  req channel carries one order word: take reduce_qty off the best level of
//  reduce_side (fifo order inside a level), then optionally rest a new order.
//  rsp channel returns one word per fill, an error word when the book runs
//  dry, the fill limit is hit or the new order is rejected, and a closing
//  summary word (tlast high) with the new order's level total and best ticks.
//  rsp_tuser carries the result kind.
// storage and sequence:
//  state lives in three synchronous rams (order fifos, level records,
//  occupancy words); every access goes through a registered read.
//  each fill reads the best level record, then its oldest order, then writes
//  both back and emits the fill word; when a best level empties, its tick is
//  cleared and further 32-tick occupancy words are scanned for the next best,
//  and a new order that opens an empty level sets its occupancy bit.
// reset:
//  a clearing pass over every address zeroes the level records and
//  occupancy words; req_tready stays low.
// stalls:
//  results pass through one output register; while it is held the sequencer
//  waits, a new item is taken as soon as the summary is registered.
module limit_order_book_fifo_match
   import lobfm_pkg::*;
#(
   parameter int PRICE_LEVELS     = 1024,
   parameter int ORDERS_PER_LEVEL = 16,
   parameter int MAX_FILLS        = 62
) (
   input  logic             clock,
   input  logic             reset,
   // reduce_side[0] reduce_qty[32:1] incoming_order_id[64:33] new_valid[65]
   // new_side[66] new_price[76:67] new_qty[108:77] new_order_id[140:109]
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // level_price[9:0] fill_qty[41:10] resting_order_id[73:42]
   // cause_order_id[105:74] level_total[141:106] trade_number[173:142]
   // bid_tick[184:174] ask_tick[195:185] error_code[197:196]
   output logic [RSP_W-1:0] rsp_tdata,
   // result_kind[1:0]
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready
);
   localparam int PL  = PRICE_LEVELS;
   localparam int OPL = ORDERS_PER_LEVEL;
   localparam int PW  = $clog2(PL);
   localparam int HW  = (OPL > 1) ? $clog2(OPL) : 1;
   localparam int CW  = $clog2(OPL + 1);
   localparam int LVW = TOTAL_W + CW + HW;
   localparam int SW  = $clog2(PL * OPL);
   localparam int NW  = (PL + WORD_BITS - 1) / WORD_BITS;
   localparam int WW  = (NW > 1) ? $clog2(NW) : 1;
   localparam int LAW = PW + 1;
   localparam int BAW = WW + 1;

   // sequencer state
   state_type state_ff, state_in;
   logic [LAW-1:0] clr_ff, clr_in;

   // item being worked on
   logic        red_side_ff;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] cause_ff;
   logic        nvalid_ff, nside_ff;
   logic [9:0]  nprice_ff;
   logic [31:0] nqty_ff, nid_ff;
   logic [5:0]  fills_ff, fills_in;
   err_type     err_ff, err_in;
   logic        rejected_ff, rejected_in;
   logic [TOTAL_W-1:0] sum_total_ff, sum_total_in;

   // best ticks per side
   logic          bid_vld_ff, bid_vld_in, ask_vld_ff, ask_vld_in;
   logic [PW-1:0] bid_px_ff, bid_px_in, ask_px_ff, ask_px_in;
   logic [31:0]   trade_ff, trade_in;
   logic [WW-1:0] scan_word_ff, scan_word_in;

   // level record latched for the fill
   logic [HW-1:0]      lvl_head_ff;
   logic [CW-1:0]      lvl_count_ff;
   logic [TOTAL_W-1:0] lvl_total_ff;
   logic [SW-1:0]      slot_ff, slot_in;

   // output register
   logic             rsp_vld_ff, rsp_vld_in;
   logic [RSP_W-1:0] rsp_data_ff;
   logic [1:0]       rsp_kind_ff;
   logic             rsp_last_ff;

   // ram ports
   logic             lv_we, lv_re;
   logic [LAW-1:0]   lv_waddr, lv_raddr;
   logic [LVW-1:0]   lv_wdata, lv_rdata;
   logic             st_we, st_re;
   logic [SW:0]      st_waddr, st_raddr;
   logic [63:0]      st_wdata, st_rdata;
   logic             bm_we, bm_re;
   logic [BAW-1:0]   bm_waddr, bm_raddr;
   logic [WORD_BITS-1:0] bm_wdata, bm_rdata;

   // scan unit
   logic [WORD_BITS-1:0] scan_in_word;
   logic                 scan_found;
   logic [WORD_LG-1:0]   scan_idx;

   // emitted word
   logic               emit, out_free;
   kind_type           e_kind;
   logic [9:0]         e_price;
   logic [31:0]        e_fq, e_rid, e_trade;
   logic [TOTAL_W-1:0] e_tot;
   logic signed [10:0] e_bb, e_ba;
   err_type            e_ec;
   logic               e_last;

   // datapath helpers
   logic               cur_vld, end_word;
   logic [PW-1:0]      cur_px, npx, found_px;
   logic [WW-1:0]      cur_word, next_word, fill_word, new_word;
   logic [HW-1:0]      rd_head, head_n;
   logic [CW-1:0]      rd_count, count_n;
   logic [TOTAL_W-1:0] rd_total, tot_n, tot_add;
   logic [TOTAL_W:0]   tot_sum;
   logic [31:0]        oq, x, oq_n;
   logic [CW:0]        tail_sum, tail;
   logic               n_in_range;

   lobfm_ram #(.AW(LAW), .WIDTH(LVW)) u_levels (
      .clock(clock), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
      .re(lv_re), .raddr(lv_raddr), .rdata(lv_rdata));

   lobfm_ram #(.AW(SW + 1), .WIDTH(64)) u_orders (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
      .re(st_re), .raddr(st_raddr), .rdata(st_rdata));

   lobfm_ram #(.AW(BAW), .WIDTH(WORD_BITS)) u_occupancy (
      .clock(clock), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
      .re(bm_re), .raddr(bm_raddr), .rdata(bm_rdata));

   lobfm_bitscan u_scan (
      .word(scan_in_word), .lowest(red_side_ff),
      .found(scan_found), .idx(scan_idx));

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   // level record fields as read
   assign rd_head  = lv_rdata[HW-1:0];
   assign rd_count = lv_rdata[HW+CW-1:HW];
   assign rd_total = lv_rdata[LVW-1:HW+CW];

   assign cur_vld   = red_side_ff ? ask_vld_ff : bid_vld_ff;
   assign cur_px    = red_side_ff ? ask_px_ff : bid_px_ff;
   assign npx       = PW'(nprice_ff);
   assign n_in_range = int'(nprice_ff) < PL;
   assign fill_word = WW'(cur_px >> WORD_LG);
   assign new_word  = WW'(npx >> WORD_LG);
   assign cur_word  = (state_ff == ST_BMCLR) ? fill_word : scan_word_ff;
   assign next_word = red_side_ff ? cur_word + WW'(1) : cur_word - WW'(1);
   assign end_word  = red_side_ff ? (cur_word == WW'(NW - 1)) : (cur_word == '0);
   assign found_px  = PW'({cur_word, scan_idx});
   assign scan_in_word = (state_ff == ST_BMCLR)
                         ? (bm_rdata & ~(WORD_BITS'(1) << WORD_LG'(cur_px)))
                         : bm_rdata;

   // fill arithmetic against the oldest order of the best level
   always_comb begin
      oq      = st_rdata[63:32];
      x       = (oq < rem_ff) ? oq : rem_ff;
      oq_n    = oq - x;
      tot_n   = (lvl_total_ff >= TOTAL_W'(x)) ? lvl_total_ff - TOTAL_W'(x) : '0;
      head_n  = lvl_head_ff;
      count_n = lvl_count_ff;
      if (oq_n == '0) begin
         head_n  = (int'(lvl_head_ff) == OPL - 1) ? '0 : lvl_head_ff + HW'(1);
         count_n = lvl_count_ff - CW'(1);
      end
      if (count_n == '0) begin
         head_n = '0;
         tot_n  = '0;
      end
      tail_sum = (CW+1)'(rd_head) + (CW+1)'(rd_count);
      tail     = (tail_sum >= (CW+1)'(OPL)) ? tail_sum - (CW+1)'(OPL) : tail_sum;
      tot_sum  = (TOTAL_W+1)'(rd_total) + (TOTAL_W+1)'(nqty_ff);
      tot_add  = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_RED;
         end
         ST_RED: begin
            if (rem_ff == '0) begin
               state_in = ST_NEW;
            end else if (!cur_vld || int'(fills_ff) >= MAX_FILLS) begin
               if (out_free) state_in = ST_NEW;
            end else begin
               state_in = ST_ORD;
            end
         end
         ST_ORD: state_in = ST_FILL;
         ST_FILL: begin
            if (out_free) state_in = (count_n == '0) ? ST_BMCLR : ST_RED;
         end
         ST_BMCLR, ST_SCANCHK: begin
            state_in = (scan_found || end_word) ? ST_RED : ST_SCAN;
         end
         ST_SCAN: state_in = ST_SCANCHK;
         ST_NEW: begin
            if (!nvalid_ff) begin
               state_in = ST_SUM;
            end else if (!n_in_range) begin
               if (out_free || err_ff != ERR_NONE) state_in = ST_SUM;
            end else begin
               state_in = ST_NEWLVL;
            end
         end
         ST_NEWLVL: begin
            if (int'(rd_count) >= OPL) begin
               if (out_free || err_ff != ERR_NONE) state_in = ST_SUM;
            end else begin
               state_in = (rd_count == '0) ? ST_NBSET : ST_SUM;
            end
         end
         ST_NBSET: state_in = ST_SUM;
         ST_SUM: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in       = clr_ff + LAW'(1);
      rem_in       = rem_ff;
      fills_in     = fills_ff;
      err_in       = err_ff;
      rejected_in  = rejected_ff;
      sum_total_in = sum_total_ff;
      bid_vld_in   = bid_vld_ff;
      ask_vld_in   = ask_vld_ff;
      bid_px_in    = bid_px_ff;
      ask_px_in    = ask_px_ff;
      trade_in     = trade_ff;
      scan_word_in = scan_word_ff;
      slot_in      = slot_ff;
      lv_we = 1'b0; lv_waddr = '0; lv_wdata = '0;
      lv_re = 1'b0; lv_raddr = '0;
      st_we = 1'b0; st_waddr = '0; st_wdata = '0;
      st_re = 1'b0; st_raddr = '0;
      bm_we = 1'b0; bm_waddr = '0; bm_wdata = '0;
      bm_re = 1'b0; bm_raddr = '0;
      emit = 1'b0; e_kind = KIND_FILL; e_price = '0; e_fq = '0; e_rid = '0;
      e_tot = '0; e_trade = '0; e_bb = '0; e_ba = '0; e_ec = ERR_NONE;
      e_last = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            lv_we    = 1'b1;
            lv_waddr = clr_ff;
            bm_we    = 1'b1;
            bm_waddr = clr_ff[BAW-1:0];
         end
         ST_IDLE: begin
            fills_in     = '0;
            err_in       = ERR_NONE;
            rejected_in  = 1'b0;
            sum_total_in = '0;
            rem_in       = req_tdata[32:1];
         end
         ST_RED: begin
            if (rem_ff != '0) begin
               if (!cur_vld || int'(fills_ff) >= MAX_FILLS) begin
                  if (out_free) begin
                     emit   = 1'b1;
                     e_kind = KIND_ERROR;
                     e_fq   = rem_ff;
                     e_ec   = cur_vld ? ERR_LIMIT : ERR_EMPTY;
                     err_in = e_ec;
                  end
               end else begin
                  lv_re    = 1'b1;
                  lv_raddr = {red_side_ff, cur_px};
               end
            end
         end
         ST_ORD: begin
            slot_in  = SW'(int'(cur_px) * OPL + int'(rd_head));
            st_re    = 1'b1;
            st_raddr = {red_side_ff, slot_in};
         end
         ST_FILL: begin
            if (out_free) begin
               st_we    = 1'b1;
               st_waddr = {red_side_ff, slot_ff};
               st_wdata = {oq_n, st_rdata[31:0]};
               lv_we    = 1'b1;
               lv_waddr = {red_side_ff, cur_px};
               lv_wdata = {tot_n, count_n, head_n};
               emit     = 1'b1;
               e_kind   = KIND_FILL;
               e_price  = 10'(cur_px);
               e_fq     = x;
               e_rid    = st_rdata[31:0];
               e_tot    = tot_n;
               e_trade  = trade_ff;
               trade_in = trade_ff + 32'd1;
               fills_in = fills_ff + 6'd1;
               rem_in   = rem_ff - x;
               if (count_n == '0) begin
                  bm_re    = 1'b1;
                  bm_raddr = {red_side_ff, fill_word};
               end
            end
         end
         ST_BMCLR, ST_SCANCHK: begin
            if (state_ff == ST_BMCLR) begin
               bm_we    = 1'b1;
               bm_waddr = {red_side_ff, fill_word};
               bm_wdata = scan_in_word;
            end
            if (scan_found) begin
               if (red_side_ff) ask_px_in = found_px;
               else             bid_px_in = found_px;
            end else if (end_word) begin
               if (red_side_ff) ask_vld_in = 1'b0;
               else             bid_vld_in = 1'b0;
            end else begin
               scan_word_in = next_word;
            end
         end
         ST_SCAN: begin
            bm_re    = 1'b1;
            bm_raddr = {red_side_ff, scan_word_ff};
         end
         ST_NEW: begin
            if (nvalid_ff) begin
               if (!n_in_range) begin
                  rejected_in = 1'b1;
                  if (err_ff == ERR_NONE && out_free) begin
                     emit    = 1'b1;
                     e_kind  = KIND_ERROR;
                     e_price = nprice_ff;
                     e_fq    = nqty_ff;
                     e_rid   = nid_ff;
                     e_ec    = ERR_FULL;
                  end
               end else begin
                  lv_re    = 1'b1;
                  lv_raddr = {nside_ff, npx};
               end
            end
         end
         ST_NEWLVL: begin
            if (int'(rd_count) >= OPL) begin
               rejected_in  = 1'b1;
               sum_total_in = rd_total;
               if (err_ff == ERR_NONE && out_free) begin
                  emit    = 1'b1;
                  e_kind  = KIND_ERROR;
                  e_price = nprice_ff;
                  e_fq    = nqty_ff;
                  e_rid   = nid_ff;
                  e_tot   = rd_total;
                  e_ec    = ERR_FULL;
               end
            end else begin
               st_we    = 1'b1;
               st_waddr = {nside_ff, SW'(int'(npx) * OPL + int'(tail))};
               st_wdata = {nqty_ff, nid_ff};
               lv_we    = 1'b1;
               lv_waddr = {nside_ff, npx};
               lv_wdata = {tot_add, rd_count + CW'(1), rd_head};
               sum_total_in = tot_add;
               if (nside_ff) begin
                  if (!ask_vld_ff || npx < ask_px_ff) begin
                     ask_vld_in = 1'b1;
                     ask_px_in  = npx;
                  end
               end else begin
                  if (!bid_vld_ff || npx > bid_px_ff) begin
                     bid_vld_in = 1'b1;
                     bid_px_in  = npx;
                  end
               end
               if (rd_count == '0) begin
                  bm_re    = 1'b1;
                  bm_raddr = {nside_ff, new_word};
               end
            end
         end
         ST_NBSET: begin
            bm_we    = 1'b1;
            bm_waddr = {nside_ff, new_word};
            bm_wdata = bm_rdata | (WORD_BITS'(1) << WORD_LG'(npx));
         end
         ST_SUM: begin
            if (out_free) begin
               emit    = 1'b1;
               e_kind  = KIND_SUM;
               e_price = nvalid_ff ? nprice_ff : '0;
               e_rid   = nvalid_ff ? nid_ff : '0;
               e_tot   = sum_total_ff;
               e_bb    = bid_vld_ff ? 11'(10'(bid_px_ff)) : '1;
               e_ba    = ask_vld_ff ? 11'(10'(ask_px_ff)) : '1;
               e_ec    = rejected_ff ? ERR_FULL : ERR_NONE;
               e_last  = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_vld_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         bid_vld_ff  <= 1'b0;
         ask_vld_ff  <= 1'b0;
         trade_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
         fills_ff    <= '0;
         err_ff      <= ERR_NONE;
         rejected_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         bid_vld_ff  <= bid_vld_in;
         ask_vld_ff  <= ask_vld_in;
         trade_ff    <= trade_in;
         rsp_vld_ff  <= rsp_vld_in;
         fills_ff    <= fills_in;
         err_ff      <= err_in;
         rejected_ff <= rejected_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      sum_total_ff <= sum_total_in;
      bid_px_ff    <= bid_px_in;
      ask_px_ff    <= ask_px_in;
      scan_word_ff <= scan_word_in;
      slot_ff      <= slot_in;
      if (state_ff == ST_IDLE) begin
         red_side_ff <= req_tdata[0];
         cause_ff    <= req_tdata[64:33];
         nvalid_ff   <= req_tdata[65];
         nside_ff    <= req_tdata[66];
         nprice_ff   <= req_tdata[76:67];
         nqty_ff     <= req_tdata[108:77];
         nid_ff      <= req_tdata[140:109];
      end
      if (state_ff == ST_ORD) begin
         lvl_head_ff  <= rd_head;
         lvl_count_ff <= rd_count;
         lvl_total_ff <= rd_total;
      end
      if (emit) begin
         rsp_data_ff <= {2'b00, e_ec, e_ba, e_bb, e_trade, e_tot, cause_ff,
                         e_rid, e_fq, e_price};
         rsp_kind_ff <= e_kind;
         rsp_last_ff <= e_last;
      end
   end

   // the fill counter never passes its limit
   a_fill_limit: assert property (@(posedge clock) disable iff (reset)
      int'(fills_ff) <= MAX_FILLS)
      else $error("fill count beyond limit");

   // a result is only loaded when the output register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwrote a pending word");

   // the level chosen as best must hold resting orders
   a_best_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ORD |-> rd_count != '0)
      else $error("best level read back empty");

   // only the closing summary carries tlast
   a_last_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_last_ff == (rsp_kind_ff == KIND_SUM)))
      else $error("tlast on a non-summary word");
endmodule
